/* sv/vtpy_pkg.sv */
`timescale 1ns / 1ps

package vtpy_pkg;

	// angle accumulator width, Q16 degrees, signed; covers 180 plus the full cordic sweep
	localparam int ACC_W = 26;
	localparam int ACC_FRAC = 16;

	// arctangent table length
	localparam int TABLE_LEN = 24;

	// inverse cordic gain, Q30
	localparam int GAIN_W = 30;
	localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

	// degree constants
	localparam int DEG_90 = 90;
	localparam int DEG_180 = 180;
	localparam int DEG_270 = 270;
	localparam int DEG_360 = 360;

	// atan(2^-i) in degrees, Q16, rounded to nearest
	localparam logic signed [ACC_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
		26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
		26'sd917, 26'sd458, 26'sd229, 26'sd115,
		26'sd57, 26'sd29, 26'sd14, 26'sd7,
		26'sd4, 26'sd2, 26'sd1, 26'sd0
	};

endpackage

/* sv/vtpy_cordic_stage.sv */
`timescale 1ns / 1ps

module vtpy_cordic_stage import vtpy_pkg::*; #(
	parameter int XW = 35,
	parameter int SW = 1,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ACC_W-1:0] acc_in,
	input  logic [SW-1:0]        side_in,
	output logic                 valid_out,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic signed [ACC_W-1:0] acc_out,
	output logic [SW-1:0]        side_out
);

	logic                    valid_s1;
	logic signed [XW-1:0]    x_s1;
	logic signed [XW-1:0]    y_s1;
	logic signed [ACC_W-1:0] acc_s1;
	logic [SW-1:0]           side_s1;
	logic signed [XW-1:0]    xs;
	logic signed [XW-1:0]    ys;
	logic signed [XW-1:0]    x_nxt;
	logic signed [XW-1:0]    y_nxt;
	logic signed [ACC_W-1:0] acc_nxt;

	// one micro-rotation toward y = 0
	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		if (!y_in[XW-1]) begin
			x_nxt = x_in + ys;
			y_nxt = y_in - xs;
			acc_nxt = acc_in + ATAN_Q16[IDX];
		end else begin
			x_nxt = x_in - ys;
			y_nxt = y_in + xs;
			acc_nxt = acc_in - ATAN_Q16[IDX];
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_nxt;
			y_s1 <= y_nxt;
			acc_s1 <= acc_nxt;
			side_s1 <= side_in;
		end
	end

	assign valid_out = valid_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign acc_out = acc_s1;
	assign side_out = side_s1;

endmodule

/* sv/vtpy_gain.sv */
`timescale 1ns / 1ps

module vtpy_gain import vtpy_pkg::*; #(
	parameter int XW = 35,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic signed [XW-1:0] v_in,
	input  logic [SW-1:0]        side_in,
	output logic                 valid_out,
	output logic signed [XW-1:0] h_out,
	output logic [SW-1:0]        side_out
);

	localparam int CH = 32;
	localparam int NCH = (XW + CH - 1) / CH;
	localparam int PW = NCH * CH;
	localparam int PPW = CH + GAIN_W;
	localparam int SUMW = PW + GAIN_W;
	localparam logic [SUMW-1:0] ROUND_HALF = SUMW'(1) << (GAIN_W - 1);

	logic [PW-1:0]   v_pad;
	logic [PPW-1:0]  pp_s1 [NCH];
	logic [SW-1:0]   side_s1;
	logic            valid_s1;
	logic [SUMW-1:0] sum;
	logic [XW-1:0]   h_s2;
	logic [SW-1:0]   side_s2;
	logic            valid_s2;

	// length is non-negative, so its bits go in unsigned
	assign v_pad = PW'(unsigned'(v_in));

	// sum of partial products plus half an lsb, then drop the Q30 fraction
	always_comb begin
		sum = ROUND_HALF;
		for (int k = 0; k < NCH; k++) begin
			sum = sum + (SUMW'(pp_s1[k]) << (CH * k));
		end
	end

	// valid bits of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// partial products, then the rounded sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NCH; k++) begin
				pp_s1[k] <= PPW'(v_pad[k*CH +: CH]) * PPW'(INV_GAIN_Q30);
			end
			side_s1 <= side_in;
			h_s2 <= sum[GAIN_W +: XW];
			side_s2 <= side_s1;
		end
	end

	assign valid_out = valid_s2;
	assign h_out = signed'(h_s2);
	assign side_out = side_s2;

endmodule

/* sv/vector_to_pitch_yaw.sv */
`timescale 1ns / 1ps

// channel | signals                           | direction | meaning
// vec     | vec_valid vec_stall dir_x/y/z     | in        | direction vector
// ang     | ang_valid ang_stall pitch/yaw_angle | out     | angles, 1/2^ANGLE_FRAC_BITS degree
//
// a vector enters every cycle while vec_stall is low; the pipeline registers are one prep stage,
// one register per micro-rotation in the yaw pass, two for the gain multiply, one per
// micro-rotation in the pitch pass and one output register.
// arst_n clears all valid bits; payload registers are not reset.
// a stalled result freezes the whole pipeline; vec_stall is high only then.

module vector_to_pitch_yaw import vtpy_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int CORDIC_STAGES = 16,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vec_valid,
	output logic                   vec_stall,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	output logic                   ang_valid,
	input  logic                   ang_stall,
	output logic [15:0]            pitch_angle,
	output logic [15:0]            yaw_angle
);

	localparam int W = COORD_WIDTH;
	localparam int CS = CORDIC_STAGES;
	localparam int XW = W + CS + 3;
	localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int SW1 = W + 2;
	localparam int SW2 = W + 18;
	localparam int SW3 = 18;
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (SH - 1);
	localparam logic signed [ACC_W-1:0] FULL = ACC_W'(DEG_360 << ANGLE_FRAC_BITS);
	localparam logic signed [ACC_W-1:0] ACC_180 = ACC_W'(DEG_180 << ACC_FRAC);
	localparam logic [15:0] PITCH_UP = 16'(DEG_90 << ANGLE_FRAC_BITS);
	localparam logic [15:0] PITCH_DOWN = 16'(DEG_270 << ANGLE_FRAC_BITS);

	// Q16 degrees to output units, rounded half up and wrapped into one turn
	function automatic logic [15:0] to_out(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		r = (a + RND) >>> SH;
		if (r < 0) begin
			r = r + FULL;
		end else if (r >= FULL) begin
			r = r - FULL;
		end
		return r[15:0];
	endfunction

	logic en;

	logic signed [XW-1:0] xe;
	logic signed [XW-1:0] ye;
	logic                 axis;
	logic                 zpos;

	logic                    valid_s1;
	logic signed [XW-1:0]    x_s1;
	logic signed [XW-1:0]    y_s1;
	logic signed [ACC_W-1:0] acc_s1;
	logic [SW1-1:0]          side_s1;

	logic                    yv [CS+1];
	logic signed [XW-1:0]    yx [CS+1];
	logic signed [XW-1:0]    yy [CS+1];
	logic signed [ACC_W-1:0] ya [CS+1];
	logic [SW1-1:0]          ys [CS+1];

	logic [SW2-1:0]       gside_in;
	logic                 gvalid;
	logic signed [XW-1:0] gh;
	logic [SW2-1:0]       gside;
	logic [W-1:0]         gz;

	logic                    pv [CS+1];
	logic signed [XW-1:0]    px [CS+1];
	logic signed [XW-1:0]    py [CS+1];
	logic signed [ACC_W-1:0] pa [CS+1];
	logic [SW3-1:0]          ps [CS+1];

	logic        valid_q;
	logic [15:0] pitch_q;
	logic [15:0] yaw_q;
	logic [15:0] pitch_nxt;

	// the whole pipeline moves unless a finished result is held
	assign en = !valid_q || !ang_stall;
	assign vec_stall = !en;

	// fold negative x into the right half plane and scale up
	assign xe = XW'(dir_x);
	assign ye = XW'(dir_y);
	assign axis = (dir_x == '0) && (dir_y == '0);
	assign zpos = (dir_z > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dir_x[W-1]) begin
				x_s1 <= (-xe) <<< CS;
				y_s1 <= (-ye) <<< CS;
				acc_s1 <= ACC_180;
			end else begin
				x_s1 <= xe <<< CS;
				y_s1 <= ye <<< CS;
				acc_s1 <= '0;
			end
			side_s1 <= {zpos, axis, dir_z};
		end
	end

	// yaw pass
	assign yv[0] = valid_s1;
	assign yx[0] = x_s1;
	assign yy[0] = y_s1;
	assign ya[0] = acc_s1;
	assign ys[0] = side_s1;

	for (genvar g = 0; g < CS; g++) begin : g_yaw
		vtpy_cordic_stage #(
			.XW(XW),
			.SW(SW1),
			.IDX(g)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(yv[g]),
			.x_in(yx[g]),
			.y_in(yy[g]),
			.acc_in(ya[g]),
			.side_in(ys[g]),
			.valid_out(yv[g+1]),
			.x_out(yx[g+1]),
			.y_out(yy[g+1]),
			.acc_out(ya[g+1]),
			.side_out(ys[g+1])
		);
	end

	// horizontal length times inverse gain; yaw rides along
	assign gside_in = {ys[CS], to_out(ya[CS])};

	vtpy_gain #(
		.XW(XW),
		.SW(SW2)
	) u_gain (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(yv[CS]),
		.v_in(yx[CS]),
		.side_in(gside_in),
		.valid_out(gvalid),
		.h_out(gh),
		.side_out(gside)
	);

	assign gz = gside[16 +: W];

	// pitch pass
	assign pv[0] = gvalid;
	assign px[0] = gh;
	assign py[0] = XW'(signed'(gz)) <<< CS;
	assign pa[0] = '0;
	assign ps[0] = {gside[SW2-1 -: 2], gside[15:0]};

	for (genvar g = 0; g < CS; g++) begin : g_pitch
		vtpy_cordic_stage #(
			.XW(XW),
			.SW(SW3),
			.IDX(g)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(pv[g]),
			.x_in(px[g]),
			.y_in(py[g]),
			.acc_in(pa[g]),
			.side_in(ps[g]),
			.valid_out(pv[g+1]),
			.x_out(px[g+1]),
			.y_out(py[g+1]),
			.acc_out(pa[g+1]),
			.side_out(ps[g+1])
		);
	end

	// vertical axis overrides both angles
	always_comb begin
		if (ps[CS][16]) begin
			pitch_nxt = ps[CS][17] ? PITCH_UP : PITCH_DOWN;
		end else begin
			pitch_nxt = to_out(pa[CS]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= pv[CS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= pitch_nxt;
			yaw_q <= ps[CS][16] ? 16'd0 : ps[CS][15:0];
		end
	end

	assign ang_valid = valid_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle = yaw_q;

	// a frozen pipeline keeps its last stage
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(en) |-> $stable(pv[CS]))
		else $error("pipeline moved while frozen");

	// a result only appears when the last stage held a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ang_valid) |-> $past(pv[CS]))
		else $error("result without transaction");

	// wrapped angles stay below a full turn when the turn fits in 16 bits
	if (ANGLE_FRAC_BITS <= 7) begin : g_range_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			ang_valid |-> (yaw_angle < FULL[15:0]) && (pitch_angle < FULL[15:0]))
			else $error("angle outside one turn");
	end

endmodule

/* verif/angle_monitor.sv */
`timescale 1ns / 1ps

module angle_monitor #(
	parameter int COORD_WIDTH = 16,
	parameter int CORDIC_STAGES = 16,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vec_valid,
	input  logic                          vec_stall,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	input  logic                          ang_valid,
	input  logic                          ang_stall,
	input  logic [15:0]                   pitch_angle,
	input  logic [15:0]                   yaw_angle,
	output int                            fail_count,
	output int                            pending
);

	// angles are accumulated in Q16 degrees
	localparam int ACC_FRAC = 16;
	localparam int ATAN_STEPS = 24;
	localparam int MAX_REPORTS = 10;
	localparam longint unsigned INV_GAIN = 64'd652032874;
	localparam longint DEG_90 = 90;
	localparam longint DEG_180 = 180;
	localparam longint DEG_270 = 270;
	localparam longint DEG_360 = 360;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic [15:0]                   pitch;
		logic [15:0]                   yaw;
	} angle_txn_t;

	angle_txn_t expected_angles[$];
	int mismatches = 0;

	// atan(2^-i) in Q16 degrees
	function automatic longint atan_step(int i);
		case (i)
			0: return 2949120;
			1: return 1740967;
			2: return 919879;
			3: return 466945;
			4: return 234379;
			5: return 117304;
			6: return 58666;
			7: return 29335;
			8: return 14668;
			9: return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			16: return 57;
			17: return 29;
			18: return 14;
			19: return 7;
			20: return 4;
			21: return 2;
			22: return 1;
			default: return 0;
		endcase
	endfunction

	// vectoring pass: rotate (vx, vy) onto the x axis, summing the angle
	task automatic rotate_to_axis(inout longint vx, inout longint vy, inout longint acc);
		longint xs;
		longint ys;
		for (int i = 0; i < CORDIC_STAGES && i < ATAN_STEPS; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy >= 0) begin
				vx = vx + ys;
				vy = vy - xs;
				acc = acc + atan_step(i);
			end else begin
				vx = vx - ys;
				vy = vy + xs;
				acc = acc - atan_step(i);
			end
		end
	endtask

	// round half up to the output fraction and wrap into one turn
	function automatic logic [15:0] wrap_angle(longint acc);
		longint full;
		longint r;
		full = DEG_360 << ANGLE_FRAC_BITS;
		r = (acc + (longint'(1) << (ACC_FRAC - ANGLE_FRAC_BITS - 1)))
			>>> (ACC_FRAC - ANGLE_FRAC_BITS);
		if (r < 0)
			r = r + full;
		if (r >= full)
			r = r - full;
		return r[15:0];
	endfunction

	// horizontal length times the inverse cordic gain, rounded
	function automatic longint scale_by_inv_gain(longint v);
		longint unsigned u;
		longint unsigned hi;
		longint unsigned lo;
		u = v;
		hi = u >> 32;
		lo = u & 64'hFFFF_FFFF;
		return longint'(((hi * INV_GAIN) << 2) + ((lo * INV_GAIN + (64'd1 << 29)) >> 30));
	endfunction

	task automatic predict_angles(input logic signed [COORD_WIDTH-1:0] ix,
			input logic signed [COORD_WIDTH-1:0] iy,
			input logic signed [COORD_WIDTH-1:0] iz,
			output logic [15:0] pitch, output logic [15:0] yaw);
		longint x;
		longint y;
		longint z;
		longint acc;
		longint h;
		x = longint'(ix);
		y = longint'(iy);
		z = longint'(iz);
		// vector on the vertical axis
		if (x == 0 && y == 0) begin
			acc = ((z > 0) ? DEG_90 : DEG_270) << ANGLE_FRAC_BITS;
			pitch = acc[15:0];
			yaw = 16'd0;
			return;
		end
		x = x * (longint'(1) << CORDIC_STAGES);
		y = y * (longint'(1) << CORDIC_STAGES);
		z = z * (longint'(1) << CORDIC_STAGES);
		// left half plane: turn by 180 degrees first
		acc = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = DEG_180 << ACC_FRAC;
		end
		rotate_to_axis(x, y, acc);
		yaw = wrap_angle(acc);
		h = scale_by_inv_gain(x);
		acc = 0;
		rotate_to_axis(h, z, acc);
		pitch = wrap_angle(acc);
	endtask

	// predict on each vector transaction, compare on each angle transaction
	always @(posedge clk) begin : watch
		angle_txn_t txn;
		angle_txn_t want;
		if (arst_n) begin
			if (vec_valid && !vec_stall) begin
				txn.x = dir_x;
				txn.y = dir_y;
				txn.z = dir_z;
				predict_angles(dir_x, dir_y, dir_z, txn.pitch, txn.yaw);
				expected_angles.push_back(txn);
			end
			if (ang_valid && !ang_stall) begin
				if (expected_angles.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected angle transaction pitch=%0d yaw=%0d",
							$realtime, pitch_angle, yaw_angle);
				end else begin
					want = expected_angles.pop_front();
					if (pitch_angle !== want.pitch || yaw_angle !== want.yaw) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: vec (%0d,%0d,%0d) pitch exp %0d got %0d, yaw exp %0d got %0d",
								$realtime, want.x, want.y, want.z, want.pitch, pitch_angle,
								want.yaw, yaw_angle);
					end
				end
			end
		end
		fail_count <= mismatches;
		pending <= expected_angles.size();
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int COORD_WIDTH = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int LATENCY = 2 * CORDIC_STAGES + 4;
	localparam int DRAIN_CYCLES = LATENCY + 16;
	localparam int RANDOM_ITEMS = 1200;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_HOLD} stall_mode_t;

	logic                          clk;
	logic                          arst_n;
	logic                          vec_valid;
	logic                          vec_stall;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;
	logic signed [COORD_WIDTH-1:0] dir_z;
	logic                          ang_valid;
	logic                          ang_stall;
	logic [15:0]                   pitch_angle;
	logic [15:0]                   yaw_angle;
	int                            fail_count;
	int                            pending;
	int                            cycle_count = 0;

	vector_to_pitch_yaw #(
		.COORD_WIDTH(COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.vec_valid(vec_valid),
		.vec_stall(vec_stall),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.ang_valid(ang_valid),
		.ang_stall(ang_stall),
		.pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle)
	);

	angle_monitor #(
		.COORD_WIDTH(COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_angle_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.vec_valid(vec_valid),
		.vec_stall(vec_stall),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.ang_valid(ang_valid),
		.ang_stall(ang_stall),
		.pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle),
		.fail_count(fail_count),
		.pending(pending)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one vector and hold it until the transaction completes
	task automatic offer_vector(input logic signed [COORD_WIDTH-1:0] x,
			input logic signed [COORD_WIDTH-1:0] y, input logic signed [COORD_WIDTH-1:0] z);
		vec_valid <= 1'b1;
		dir_x <= x;
		dir_y <= y;
		dir_z <= z;
		@(posedge clk);
		while (vec_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		vec_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic signed [COORD_WIDTH-1:0] edge_coord();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// receiver stall pattern, with one long hold-off to fill the pipeline
	initial begin : ang_stall_gen
		stall_mode_t mode;
		int left;
		int seg;
		ang_stall = 1'b0;
		mode = STALL_NONE;
		left = 0;
		seg = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				seg++;
				if (seg == 5) begin
					mode = STALL_HOLD;
					left = HOLD_CYCLES;
				end else begin
					mode = stall_mode_t'($urandom_range(0, 3));
					left = $urandom_range(10, 150);
				end
			end
			left--;
			case (mode)
				STALL_NONE: ang_stall <= 1'b0;
				STALL_LIGHT: ang_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: ang_stall <= ($urandom_range(0, 3) != 0);
				STALL_TOGGLE: ang_stall <= ~ang_stall;
				default: ang_stall <= 1'b1;
			endcase
		end
	end

	// stimulus and verdict
	initial begin : vec_stim
		int sent;
		int burst;
		int kind;
		logic signed [COORD_WIDTH-1:0] rx;
		logic signed [COORD_WIDTH-1:0] ry;
		logic signed [COORD_WIDTH-1:0] rz;
		arst_n = 1'b0;
		vec_valid = 1'b0;
		dir_x = '0;
		dir_y = '0;
		dir_z = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// vertical axis, zero vector included
		offer_vector(0, 0, 0);
		offer_vector(0, 0, 1);
		offer_vector(0, 0, -1);
		offer_vector(0, 0, 32767);
		offer_vector(0, 0, -32768);
		// axes and field extremes
		offer_vector(1, 0, 0);
		offer_vector(0, 1, 0);
		offer_vector(0, -1, 0);
		offer_vector(-1, 0, 0);
		offer_vector(32767, 32767, 32767);
		offer_vector(-32768, -32768, -32768);
		offer_vector(-32768, 32767, -32768);
		offer_vector(32767, -32768, 32767);
		offer_vector(-32768, 0, 0);
		offer_vector(0, -32768, 1);
		// negative x, just either side of 180 degrees
		offer_vector(-32768, -1, 0);
		offer_vector(-32768, 1, 0);
		// just below a full turn, then steep and mixed vectors
		pause_sender(3);
		offer_vector(32767, -1, 0);
		offer_vector(32767, 0, -1);
		offer_vector(32767, -1, -1);
		offer_vector(1, 0, -32768);
		offer_vector(-1, -1, 32767);
		offer_vector(1, 1, 1);

		// random vectors in bursts
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				kind = $urandom_range(0, 99);
				rx = COORD_WIDTH'($urandom);
				ry = COORD_WIDTH'($urandom);
				rz = COORD_WIDTH'($urandom);
				if (kind >= 55 && kind < 70) begin
					rx = COORD_WIDTH'($urandom_range(0, 16) - 8);
					ry = COORD_WIDTH'($urandom_range(0, 16) - 8);
					rz = COORD_WIDTH'($urandom_range(0, 16) - 8);
				end else if (kind >= 70 && kind < 80) begin
					rx = 0;
					ry = 0;
				end else if (kind >= 80 && kind < 90) begin
					ry = COORD_WIDTH'($urandom_range(0, 6) - 3);
				end else if (kind >= 90) begin
					rx = edge_coord();
					ry = edge_coord();
					rz = edge_coord();
				end
				offer_vector(rx, ry, rz);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 15));
		end
		vec_valid <= 1'b0;

		// drain
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
